FILE: rtl/sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// concurrent checks used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SPQ_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t op;
    entry_t   entry;
  } cell_cmd_t;

endpackage

FILE: rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: compares against a pushed priority and
// shifts toward the tail on insert or toward the head on pop
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,    // slot index below the held count
  input  logic      prev_ge,     // head-side neighbor keeps its place
  input  entry_t    prev_entry,  // head-side neighbor's entry
  input  entry_t    next_entry,  // tail-side neighbor's entry
  output entry_t    entry,
  output logic      ge           // this slot keeps its place on a push
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry = entry_r;
  assign ge    = occupied && (entry_r.prio >= cmd.entry.prio);

  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.op)
      CELL_PUSH: begin
        if (!ge) begin
          entry_nxt = prev_ge ? cmd.entry : prev_entry;
        end
      end
      CELL_POP: begin
        entry_nxt = next_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// priority queue held as a row of cells sorted by priority, head first
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/tready     tuser: req_type, tdata: value, priority
//  out_     out  out_tvalid/tready    tuser: status, tdata: value, priority, count
//  cfg_     in   cfg_valid/ready      cfg_data: capacity
//
//  one transaction per cycle: every cell compares the pushed priority and
//  shifts in the same cycle, the result lands in the output register next edge
//  a new request is taken while the output register is empty or being drained
//  rst_n (synchronous) empties the queue and sets capacity to 16
//  stored entries are not cleared; only slots below the count are ever read
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] value, [47:32] priority_req
  input  logic [0:0]  in_tuser,   // [0] req_type

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] out_value, [47:32] out_priority, [52:48] count
  output logic [1:0]  out_tuser,  // [1:0] status

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // capacity
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // control state
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic              out_valid_r;

  // output payload
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [PRIO_W-1:0]  out_prio_r, out_prio_nxt;
  logic [COUNT_W-1:0] out_count_r;

  // cell row
  cell_cmd_t       cmd;
  entry_t          cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_ge;
  logic [DEPTH-1:0] occupied;

  logic in_acc;
  logic req_pop;
  logic full;
  logic empty;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign req_pop   = (in_tuser[0] == REQ_POP);
  assign cfg_ready = 1'b1;

  // capacity above the row length is clipped to the row
  assign full  = (CMP_W'(count_r) >= CMP_W'(cap_r)) || (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // request decode into a broadcast cell command
  always_comb begin
    cmd.op          = CELL_HOLD;
    cmd.entry.value = in_tdata[31:0];
    cmd.entry.prio  = in_tdata[47:32];
    count_nxt       = count_r;
    out_status_nxt  = ST_OK;
    out_value_nxt   = '0;
    out_prio_nxt    = '0;
    if (req_pop) begin
      if (empty) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        cmd.op        = in_acc ? CELL_POP : CELL_HOLD;
        out_value_nxt = cell_entry[0].value;
        out_prio_nxt  = cell_entry[0].prio;
        count_nxt     = count_r - 1'b1;
      end
    end else begin
      if (full) begin
        out_status_nxt = ST_OVERFLOW;
      end else begin
        cmd.op    = in_acc ? CELL_PUSH : CELL_HOLD;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // row of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occupied[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (occupied[i]),
        .prev_ge    (1'b1),
        .prev_entry (cmd.entry),
        .next_entry (cell_entry[i+1]),
        .entry      (cell_entry[i]),
        .ge         (cell_ge[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (occupied[i]),
        .prev_ge    (cell_ge[i-1]),
        .prev_entry (cell_entry[i-1]),
        .next_entry (cell_entry[i]),
        .entry      (cell_entry[i]),
        .ge         (cell_ge[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (occupied[i]),
        .prev_ge    (cell_ge[i-1]),
        .prev_entry (cell_entry[i-1]),
        .next_entry (cell_entry[i+1]),
        .entry      (cell_entry[i]),
        .ge         (cell_ge[i])
      );
    end
  end

  // count, capacity and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_prio_r   <= out_prio_nxt;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_count_r, out_prio_r, out_value_r};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `include "sorted_priority_queue_assert.svh"

  `SPQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `SPQ_ASSERT_NEXT(a_push_grows, clk, rst_n, in_acc && !req_pop && !full, count_r == CNT_W'($past(count_r) + 1'b1), "push did not grow count")
  `SPQ_ASSERT_NEXT(a_pop_ok, clk, rst_n, in_acc && req_pop && !empty, out_tvalid && (out_tuser == ST_OK) && (out_tdata[31:0] == $past(cell_entry[0].value)), "pop result wrong")
  `SPQ_ASSERT_SAME(a_head_sorted, clk, rst_n, occupied[1], cell_entry[0].prio >= cell_entry[1].prio, "head out of order")

endmodule

FILE: tb/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// self-checking bench: push/pop requests with random gaps and stalls, every
// result checked against a sorted-list predictor, capacity moved between phases
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 110;

  // one expected or observed result transaction
  typedef struct {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    logic [COUNT_W-1:0]        count;
  } pq_result_t;

  // predictor of the queue plus the fifo of results still owed by the block
  class pq_scoreboard;
    entry_t            held_entries[$];
    pq_result_t        expected_results[$];
    logic [CAP_W-1:0]  capacity;
    int                errors;
    int                pushes;
    int                pops;
    int                overflows;
    int                empties;

    function new();
      capacity = CAP_RESET;
    endfunction

    function void set_capacity(input logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    // work out the result of one accepted request and update the held list
    function void note_request(input logic kind, input logic signed [VALUE_W-1:0] v,
                               input logic signed [PRIO_W-1:0] p);
      pq_result_t r;
      entry_t     e;
      int         limit;
      int         pos;
      r.status = ST_OK;
      r.value  = '0;
      r.prio   = '0;
      limit    = (int'(capacity) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(capacity);
      if (kind == REQ_PUSH) begin
        pushes++;
        if (held_entries.size() >= limit) begin
          r.status = ST_OVERFLOW;
          overflows++;
        end else begin
          // new entry goes behind every entry of greater or equal priority
          e.value = v;
          e.prio  = p;
          pos = held_entries.size();
          while (pos > 0 && $signed(held_entries[pos-1].prio) < $signed(p))
            pos--;
          held_entries.insert(pos, e);
        end
      end else begin
        pops++;
        if (held_entries.size() == 0) begin
          r.status = ST_EMPTY;
          empties++;
        end else begin
          e = held_entries.pop_front();
          r.value = e.value;
          r.prio  = e.prio;
        end
      end
      r.count = COUNT_W'(held_entries.size());
      expected_results.push_back(r);
    endfunction

    function void check_result(input pq_result_t got);
      pq_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d value %0d prio %0d count %0d",
                 $time, got.status, got.value, got.prio, got.count);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.value !== want.value) begin
        $display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
        errors++;
      end
      if (got.prio !== want.prio) begin
        $display("%0t: priority expected %0d actual %0d", $time, want.prio, got.prio);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [31:0] value, [47:32] priority_req
  logic [0:0]  in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [31:0] out_value, [47:32] out_priority, [52:48] count
  logic [1:0]  out_tuser;  // [1:0] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;   // capacity

  pq_scoreboard board = new();
  bit           no_gaps;       // set during the stretch without idle cycles
  int           cfg_writes;
  logic [CAP_W-1:0] phase_caps [NUM_PHASES];
  int               phase_push_pct [NUM_PHASES];

  sorted_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stalls at random except in the quiet stretch
  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= 6);
  end

  // request monitor feeds the predictor on each accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      board.note_request(in_tuser[0], in_tdata[31:0], in_tdata[47:32]);
  end

  // result monitor
  always @(posedge clk) begin
    pq_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.value  = out_tdata[31:0];
      got.prio   = out_tdata[47:32];
      got.count  = out_tdata[52:48];
      board.check_result(got);
    end
  end

  // one request transaction, with a random idle gap in front of it
  task automatic send_request(input logic kind, input logic signed [VALUE_W-1:0] v,
                              input logic signed [PRIO_W-1:0] p);
    while (!no_gaps && $urandom_range(0, 99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {p, v};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  // capacity is only changed with the queue pipeline empty
  task automatic write_capacity(input logic [CAP_W-1:0] c);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_capacity(c);
    cfg_writes++;
  endtask

  // mostly small priorities so ties are common, some extremes, some anything
  function automatic logic signed [PRIO_W-1:0] random_priority();
    logic signed [PRIO_W-1:0] r;
    case ($urandom_range(0, 3))
      0, 1: begin
        r = PRIO_W'($urandom_range(0, 4));
        r = r - 16'sd2;
      end
      2: r = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: r = PRIO_W'($urandom);
    endcase
    return r;
  endfunction

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic kind;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    no_gaps    = 1'b0;
    cfg_writes = 0;

    // capacities per phase: above depth, lowered below the held count, zero, one
    phase_caps     = '{5'd31, 5'd16, 5'd3, 5'd1, 5'd0, 5'd7,
                       5'd16, 5'd2, 5'd31, 5'd12, 5'd16, 5'd5};
    phase_push_pct = '{80, 40, 70, 50, 50, 60, 85, 50, 30, 60, 20, 50};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pop from empty, extremes of value and priority, ties in order
    send_request(REQ_POP,  32'sd0, 16'sd0);
    send_request(REQ_PUSH, 32'sh7fffffff, 16'sh7fff);
    send_request(REQ_PUSH, 32'sh80000000, 16'sh8000);
    send_request(REQ_PUSH, 32'sd0, 16'sd0);
    send_request(REQ_PUSH, -32'sd1, -16'sd1);
    send_request(REQ_PUSH, 32'sd5, 16'sd0);
    send_request(REQ_PUSH, 32'sd6, 16'sh7fff);
    repeat (6) send_request(REQ_POP, 32'sh5a5a5a5a, 16'sh5a5a);
    send_request(REQ_POP, -32'sd1, -16'sd1);
    in_tvalid <= 1'b0;

    // capacity zero: every push overflows
    write_capacity(5'd0);
    send_request(REQ_PUSH, 32'sd7, 16'sd3);
    send_request(REQ_POP,  32'sd0, 16'sd0);
    in_tvalid <= 1'b0;

    // small capacity: third push overflows
    write_capacity(5'd2);
    send_request(REQ_PUSH, 32'sd10, 16'sd1);
    send_request(REQ_PUSH, 32'sd11, 16'sd2);
    send_request(REQ_PUSH, 32'sd12, 16'sd3);
    in_tvalid <= 1'b0;

    // random phases; held entries carry over between capacity changes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      no_gaps = (ph == 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = ($urandom_range(0, 99) < phase_push_pct[ph]) ? REQ_PUSH : REQ_POP;
        send_request(kind, VALUE_W'($urandom), random_priority());
      end
      in_tvalid <= 1'b0;
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);

    $display("covered %0d pushes (%0d overflowed) and %0d pops (%0d on empty queue)",
             board.pushes, board.overflows, board.pops, board.empties);
    $display("over %0d capacity writes including zero and above depth", cfg_writes);
    if (board.errors == 0 && board.outstanding() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
